// ===== src/spf_pkg.sv =====
// shared types and constants for the slip packet framer
package spf_pkg;

    localparam logic [7:0] CODE_END     = 8'hC0;
    localparam logic [7:0] CODE_ESC     = 8'hDB;
    localparam logic [7:0] CODE_ESC_END = 8'hDC;
    localparam logic [7:0] CODE_ESC_ESC = 8'hDD;

    localparam int HDR_BYTES = 12;
    localparam int TRAILER_BYTES = 4;
    localparam logic [7:0] LEN_BASE = 8'(HDR_BYTES + TRAILER_BYTES);

    localparam int ONES_W = 11;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    typedef enum logic {
        KIND_START,
        KIND_DATA
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic              close;
        logic [15:0]       frag_word;
        logic [7:0]        total_len;
        logic [15:0]       frame_id;
        logic [7:0]        protocol;
        logic [7:0]        checksum;
        logic [15:0]       own_address;
        logic [15:0]       dest_address;
        logic [7:0]        cmd_byte;
        logic [7:0]        len_byte;
        logic [7:0]        data_byte;
        logic [ONES_W-1:0] ones_total;
    } entry_t;

    typedef enum logic [4:0] {
        STEP_OPEN,
        STEP_HDR0,
        STEP_HDR1,
        STEP_HDR2,
        STEP_HDR3,
        STEP_HDR4,
        STEP_HDR5,
        STEP_HDR6,
        STEP_HDR7,
        STEP_HDR8,
        STEP_HDR9,
        STEP_HDR10,
        STEP_HDR11,
        STEP_CMD,
        STEP_LEN,
        STEP_DATA,
        STEP_ONES_HI,
        STEP_ONES_LO,
        STEP_CLOSE
    } step_t;

endpackage

// ===== src/spf_if.sv =====
// channel interfaces for items, line bytes and the address register
interface spf_item_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [7:0]  protocol;
    logic [15:0] dest_address;
    logic [2:0]  flags;
    logic [12:0] frag_offset;
    logic [7:0]  command;
    logic [7:0]  length;
    logic [7:0]  data_byte;

    modport source (
        output valid, op, protocol, dest_address, flags, frag_offset, command, length,
               data_byte,
        input  ready
    );
    modport sink (
        input  valid, op, protocol, dest_address, flags, frag_offset, command, length,
               data_byte,
        output ready
    );
endinterface

interface spf_line_if;
    logic       valid;
    logic       ready;
    logic [7:0] wire_byte;
    logic       frame_end;

    modport source (output valid, wire_byte, frame_end, input ready);
    modport sink (input valid, wire_byte, frame_end, output ready);
endinterface

interface spf_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] own_address;

    modport source (output valid, own_address, input ready);
    modport sink (input valid, own_address, output ready);
endinterface

// ===== src/spf_front.sv =====
// front end: accepts items, tracks frame state and builds queue entries
module spf_front (
    input  logic            clk,
    input  logic            rst_n,
    spf_item_if.sink        item,
    spf_cfg_if.sink         cfg,
    output logic            push_valid,
    output spf_pkg::entry_t push_entry,
    input  logic            push_ready
);
    import spf_pkg::*;

    logic [15:0]       own_addr_reg;
    logic [15:0]       frame_id_reg;
    logic [7:0]        bytes_left_reg;
    logic [ONES_W-1:0] ones_reg;

    logic [15:0]       frag;
    logic [7:0]        total_len;
    logic [7:0]        hdr_sum;
    logic [3:0]        pop_cnt;
    logic [ONES_W-1:0] ones_next;
    logic              accept;
    logic              keep;
    logic              last_data;

    function automatic logic [3:0] count_ones(input logic [7:0] b);
        logic [3:0] c;
        c = 4'd0;
        for (int j = 0; j < 8; j++)
        begin
            c = c + {3'b000, b[j]};
        end
        return c;
    endfunction

    assign cfg.ready  = 1'b1;
    assign item.ready = push_ready;

    always_comb
    begin
        frag      = {item.flags, item.frag_offset};
        total_len = LEN_BASE + item.length;
        hdr_sum   = frag[15:8] + frag[7:0] + total_len + frame_id_reg[15:8]
                  + frame_id_reg[7:0] + item.protocol + own_addr_reg[15:8]
                  + own_addr_reg[7:0] + item.dest_address[15:8] + item.dest_address[7:0];
        pop_cnt   = count_ones(item.data_byte);
        ones_next = ones_reg + {{(ONES_W-4){1'b0}}, pop_cnt};
        accept    = item.valid && item.ready;
        keep      = (item.op == OP_START) || (bytes_left_reg != 8'd0);
        last_data = (bytes_left_reg == 8'd1);
        push_valid = accept && keep;

        push_entry.kind         = (item.op == OP_START) ? KIND_START : KIND_DATA;
        push_entry.close        = (item.op == OP_START) ? (item.length == 8'd0) : last_data;
        push_entry.frag_word    = frag;
        push_entry.total_len    = total_len;
        push_entry.frame_id     = frame_id_reg;
        push_entry.protocol     = item.protocol;
        push_entry.checksum     = ~hdr_sum;
        push_entry.own_address  = own_addr_reg;
        push_entry.dest_address = item.dest_address;
        push_entry.cmd_byte     = item.command;
        push_entry.len_byte     = item.length;
        push_entry.data_byte    = item.data_byte;
        push_entry.ones_total   = (item.op == OP_START) ? '0 : ones_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_addr_reg   <= '0;
            frame_id_reg   <= '0;
            bytes_left_reg <= '0;
            ones_reg       <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                own_addr_reg <= cfg.own_address;
            end
            if (accept)
            begin
                if (item.op == OP_START)
                begin
                    frame_id_reg   <= frame_id_reg + 16'd1;
                    bytes_left_reg <= item.length;
                    ones_reg       <= '0;
                end
                else if (bytes_left_reg != 8'd0)
                begin
                    bytes_left_reg <= bytes_left_reg - 8'd1;
                    ones_reg       <= last_data ? '0 : ones_next;
                end
            end
        end
    end

endmodule

// ===== src/spf_queue.sv =====
// short entry queue between front end and byte sequencer
module spf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  spf_pkg::entry_t push_entry,
    output logic            push_ready,
    output logic            pop_valid,
    output spf_pkg::entry_t pop_entry,
    input  logic            pop_ready
);
    import spf_pkg::*;

    entry_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               do_push;
    logic               do_pop;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

// ===== src/spf_back.sv =====
// byte sequencer: walks each entry, escapes bytes and drives the line register
module spf_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  spf_pkg::entry_t head,
    output logic            pop,
    spf_line_if.source      line
);
    import spf_pkg::*;

    step_t      step_reg;
    step_t      step_next;
    logic       active_reg;
    logic       active_next;
    logic       esc_reg;
    logic       esc_next;
    logic       line_valid_reg;
    logic       line_valid_next;
    logic [7:0] wire_byte_reg;
    logic [7:0] wire_byte_next;
    logic       frame_end_reg;
    logic       frame_end_next;

    step_t      cur_step;
    step_t      after_step;
    logic [7:0] raw_byte;
    logic       is_raw;
    logic       needs_esc;
    logic       step_done;
    logic       last_step;
    logic       slot_free;
    logic       fire;

    function automatic logic [7:0] byte_of(input entry_t e, input step_t s);
        logic [7:0] b;
        unique case (s)
            STEP_OPEN:    b = CODE_END;
            STEP_HDR0:    b = e.frag_word[15:8];
            STEP_HDR1:    b = e.frag_word[7:0];
            STEP_HDR2:    b = e.total_len;
            STEP_HDR3:    b = 8'h00;
            STEP_HDR4:    b = e.frame_id[15:8];
            STEP_HDR5:    b = e.frame_id[7:0];
            STEP_HDR6:    b = e.protocol;
            STEP_HDR7:    b = e.checksum;
            STEP_HDR8:    b = e.own_address[15:8];
            STEP_HDR9:    b = e.own_address[7:0];
            STEP_HDR10:   b = e.dest_address[15:8];
            STEP_HDR11:   b = e.dest_address[7:0];
            STEP_CMD:     b = e.cmd_byte;
            STEP_LEN:     b = e.len_byte;
            STEP_DATA:    b = e.data_byte;
            STEP_ONES_HI: b = 8'(e.ones_total >> 8);
            STEP_ONES_LO: b = e.ones_total[7:0];
            STEP_CLOSE:   b = CODE_END;
            default:      b = 8'h00;
        endcase
        return b;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= STEP_OPEN;
            active_reg     <= 1'b0;
            esc_reg        <= 1'b0;
            line_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg       <= step_next;
            active_reg     <= active_next;
            esc_reg        <= esc_next;
            line_valid_reg <= line_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wire_byte_reg <= wire_byte_next;
        frame_end_reg <= frame_end_next;
    end

    always_comb
    begin
        cur_step = active_reg ? step_reg
                 : ((head.kind == KIND_START) ? STEP_OPEN : STEP_DATA);
        raw_byte  = byte_of(head, cur_step);
        is_raw    = (cur_step == STEP_OPEN) || (cur_step == STEP_CLOSE);
        needs_esc = !is_raw && ((raw_byte == CODE_END) || (raw_byte == CODE_ESC));
        step_done = esc_reg || !needs_esc;

        last_step  = 1'b0;
        after_step = step_t'(cur_step + 5'd1);
        unique case (cur_step)
            STEP_LEN, STEP_DATA:
            begin
                after_step = STEP_ONES_HI;
                last_step  = !head.close;
            end
            STEP_CLOSE:
            begin
                last_step = 1'b1;
            end
            default:
            begin
            end
        endcase

        slot_free = !line_valid_reg || line.ready;
        fire      = head_valid && slot_free;

        step_next       = step_reg;
        active_next     = active_reg;
        esc_next        = esc_reg;
        pop             = 1'b0;
        line_valid_next = line.ready ? 1'b0 : line_valid_reg;
        wire_byte_next  = wire_byte_reg;
        frame_end_next  = frame_end_reg;

        if (fire)
        begin
            line_valid_next = 1'b1;
            frame_end_next  = (cur_step == STEP_CLOSE);
            if (esc_reg)
            begin
                wire_byte_next = (raw_byte == CODE_END) ? CODE_ESC_END : CODE_ESC_ESC;
            end
            else if (needs_esc)
            begin
                wire_byte_next = CODE_ESC;
            end
            else
            begin
                wire_byte_next = raw_byte;
            end

            if (!step_done)
            begin
                esc_next    = 1'b1;
                active_next = 1'b1;
                step_next   = cur_step;
            end
            else if (last_step)
            begin
                esc_next    = 1'b0;
                active_next = 1'b0;
                pop         = 1'b1;
            end
            else
            begin
                esc_next    = 1'b0;
                active_next = 1'b1;
                step_next   = after_step;
            end
        end
    end

    assign line.valid     = line_valid_reg;
    assign line.wire_byte = wire_byte_reg;
    assign line.frame_end = frame_end_reg;

endmodule

// ===== src/slip_packet_framer_unit.sv =====
// slip packet framer top level
// a start item puts 15 to 26 bytes on the line, 18 to 28 when the length is zero
// a data item in an open frame puts one or two bytes, three or four more if it ends the frame
// one line byte per cycle while the line is ready and an entry is waiting
// first byte passes the queue and the line register; a two-entry queue decouples the sides
// rst_n clears frame id, open-frame count, one-bit count, own address and all handshake state
module slip_packet_framer_unit (
    input  logic       clk,
    input  logic       rst_n,
    spf_item_if.sink   item,
    spf_line_if.source line,
    spf_cfg_if.sink    cfg
);
    import spf_pkg::*;

    logic   push_valid;
    entry_t push_entry;
    logic   push_ready;
    logic   head_valid;
    entry_t head;
    logic   pop;

    spf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready)
    );

    spf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop_valid  (head_valid),
        .pop_entry  (head),
        .pop_ready  (pop)
    );

    spf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .line       (line)
    );

endmodule

// ===== src/spf_checker.sv =====
// port-level checks for the slip packet framer and their bind
module spf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       line_valid,
    input logic       line_ready,
    input logic [7:0] wire_byte,
    input logic       frame_end
);
    import spf_pkg::*;

    logic esc_open_reg;
    logic line_take;

    assign line_take = line_valid && line_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_open_reg <= 1'b0;
        end
        else if (line_take)
        begin
            esc_open_reg <= (wire_byte == CODE_ESC);
        end
    end

    // escape prefix is always followed by one of the two escape codes
    a_esc_pair: assert property (@(posedge clk) disable iff (!rst_n)
        line_take && esc_open_reg |-> (wire_byte == CODE_ESC_END) || (wire_byte == CODE_ESC_ESC))
        else $error("escape prefix not followed by escape code");

    // a frame close is always the raw end code
    a_close_byte: assert property (@(posedge clk) disable iff (!rst_n)
        line_valid && frame_end |-> wire_byte == CODE_END)
        else $error("frame close without end code");

    // the byte after an escape prefix never closes the frame
    a_no_end_after_esc: assert property (@(posedge clk) disable iff (!rst_n)
        line_take && esc_open_reg |-> !frame_end)
        else $error("frame closed inside escape");

    // stalled line byte holds
    a_line_hold: assert property (@(posedge clk) disable iff (!rst_n)
        line_valid && !line_ready |=> line_valid && $stable(wire_byte) && $stable(frame_end))
        else $error("line byte changed while stalled");

endmodule

bind slip_packet_framer_unit spf_checker u_spf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .line_valid (line.valid),
    .line_ready (line.ready),
    .wire_byte  (line.wire_byte),
    .frame_end  (line.frame_end)
);
